### rtl/vpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_pkg
// Shared types and constants for the velocity-form PID controller with
// deadband: fixed-point widths, register indexes and inter-stage structs.
// ----------------------------------------------------------------------------
package vpid_pkg;

    // Field widths (Q4.12 errors, Q2.12 drive, Q8.8 gains).
    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int TOL_W   = 15;
    localparam int DRIVE_W = 14;
    localparam int MAG_W   = 8;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Gain sums need two extra bits (kp+ki+kd and kp+2*kd).
    localparam int GSUM_W = GAIN_W + 2;
    // Exact product of an error and a gain sum, Q.20.
    localparam int PROD_W = ERR_W + GSUM_W;
    // Accumulator: three products plus the shifted drive, with headroom.
    localparam int ACC_W  = PROD_W + 4;

    // Plus one in Q4.12, and the same limit in Q.20.
    localparam int ONE_Q12 = 4096;
    localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(ONE_Q12 * 256);
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(ONE_Q12);
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = DRIVE_W'(-ONE_Q12);

    // Deadband reset value: 0.005 in Q4.12, truncated.
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(20);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN  = 8'd0,
        REG_KI_GAIN  = 8'd1,
        REG_KD_GAIN  = 8'd2,
        REG_DEADBAND = 8'd3
    } cfg_reg_t;

    // Current gains and deadband as seen by the datapath.
    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic        [TOL_W-1:0]  tol;
    } cfg_t;

    // Registered products and the deadband decision for one item.
    typedef struct packed {
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
        logic                     in_deadband;
    } prod_t;

endpackage : vpid_pkg
`default_nettype wire

### rtl/vpid_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_cfg
// Configuration register file: gains and deadband tolerance, written
// through a valid/ready port. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module vpid_cfg (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 cfg_valid,
    input  wire  [vpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [vpid_pkg::CFG_DATA_W-1:0]     cfg_data,
    output vpid_pkg::cfg_t                      cfg_out
);
    import vpid_pkg::*;

    cfg_t cfg_reg;

    // The port is always ready, so a valid write lands at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp  <= '0;
            cfg_reg.ki  <= '0;
            cfg_reg.kd  <= '0;
            cfg_reg.tol <= TOL_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KP_GAIN:  cfg_reg.kp  <= $signed(cfg_data[GAIN_W-1:0]);
                REG_KI_GAIN:  cfg_reg.ki  <= $signed(cfg_data[GAIN_W-1:0]);
                REG_KD_GAIN:  cfg_reg.kd  <= $signed(cfg_data[GAIN_W-1:0]);
                REG_DEADBAND: cfg_reg.tol <= cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_out = cfg_reg;

endmodule : vpid_cfg
`default_nettype wire

### rtl/vpid_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_mul
// Product stage: forms the three combined gains, multiplies them by the
// three errors and registers the products with the deadband decision.
// ----------------------------------------------------------------------------
module vpid_mul (
    input  wire                                 aclk,
    input  wire                                 load,
    input  wire  signed [vpid_pkg::ERR_W-1:0]   e0,
    input  wire  signed [vpid_pkg::ERR_W-1:0]   e1,
    input  wire  signed [vpid_pkg::ERR_W-1:0]   e2,
    input  vpid_pkg::cfg_t                      cfg,
    output vpid_pkg::prod_t                     prod
);
    import vpid_pkg::*;

    logic signed [GSUM_W-1:0] g0;
    logic signed [GSUM_W-1:0] g1;
    logic signed [ERR_W:0]    e0_ext;
    logic signed [ERR_W:0]    tol_pos;
    logic signed [ERR_W:0]    tol_neg;
    prod_t                    prod_next;
    prod_t                    prod_reg;

    // Combined gains: kp+ki+kd for e0 and kp+2*kd for e1.
    assign g0 = GSUM_W'(cfg.kp) + GSUM_W'(cfg.ki) + GSUM_W'(cfg.kd);
    assign g1 = GSUM_W'(cfg.kp) + (GSUM_W'(cfg.kd) <<< 1);

    // Deadband: strictly inside the open interval (-tol, tol).
    assign e0_ext  = (ERR_W+1)'(e0);
    assign tol_pos = $signed({{(ERR_W+1-TOL_W){1'b0}}, cfg.tol});
    assign tol_neg = -tol_pos;

    // Exact products in Q.20.
    always_comb begin
        prod_next.p0 = PROD_W'(g0) * PROD_W'(e0);
        prod_next.p1 = PROD_W'(g1) * PROD_W'(e1);
        prod_next.p2 = PROD_W'(cfg.kd) * PROD_W'(e2);
        prod_next.in_deadband = (e0_ext < tol_pos) && (e0_ext > tol_neg);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule : vpid_mul
`default_nettype wire

### rtl/vpid_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vpid_acc
// Accumulate stage: adds the products to the running drive, clamps to
// plus or minus 1.0, applies the deadband and forms direction and duty.
// The drive output register is also the running drive state.
// ----------------------------------------------------------------------------
module vpid_acc (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    input  wire                                     load,
    input  vpid_pkg::prod_t                         prod,
    output logic signed [vpid_pkg::DRIVE_W-1:0]     drive_level,
    output logic                                    reverse_dir,
    output logic        [vpid_pkg::MAG_W-1:0]       drive_magnitude
);
    import vpid_pkg::*;

    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;
    logic                      reverse_reg;
    logic                      reverse_next;
    logic        [MAG_W-1:0]   mag_reg;
    logic        [MAG_W-1:0]   mag_next;
    logic signed [ACC_W-1:0]   acc;
    logic        [DRIVE_W-2:0] abs_drive;
    logic        [DRIVE_W+6:0] scaled;

    // Running drive moved to Q.20 plus the three products.
    assign acc = (ACC_W'(drive_reg) <<< 8) + ACC_W'(prod.p0)
               - ACC_W'(prod.p1) + ACC_W'(prod.p2);

    // Clamp first; the deadband only applies when no clamp happened.
    // The arithmetic shift rounds toward minus infinity.
    always_comb begin
        if (acc > ACC_LIM) begin
            drive_next = DRIVE_MAX;
        end else if (acc < -ACC_LIM) begin
            drive_next = DRIVE_MIN;
        end else if (prod.in_deadband) begin
            drive_next = '0;
        end else begin
            drive_next = acc[DRIVE_W+7:8];
        end
    end

    // Direction flag and duty: (|drive| * 255) >> 12 as a shift and subtract.
    always_comb begin
        reverse_next = !drive_next[DRIVE_W-1];
        abs_drive    = drive_next[DRIVE_W-1] ? (DRIVE_W-1)'(-drive_next)
                                             : drive_next[DRIVE_W-2:0];
        scaled       = {abs_drive, 8'b0} - {8'b0, abs_drive};
        mag_next     = scaled[19:12];
    end

    // Running drive, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= '0;
        end else if (load) begin
            drive_reg <= drive_next;
        end
    end

    // Remaining result fields.
    always_ff @(posedge aclk) begin
        if (load) begin
            reverse_reg <= reverse_next;
            mag_reg     <= mag_next;
        end
    end

    assign drive_level     = drive_reg;
    assign reverse_dir     = reverse_reg;
    assign drive_magnitude = mag_reg;

endmodule : vpid_acc
`default_nettype wire

### rtl/velocity_pid_with_deadband.sv
// An accepted item is loaded into the input register on the accepting edge,
// then moves on into the product register and then the result register.
// Throughput is one item per cycle while m_ready holds; each stage moves on when
// the one after it is empty or moving, so bubbles are taken up while a result waits.
// Reset: synchronous, active low; clears the stage valid bits and the running
// drive, sets gains to zero and the deadband tolerance to 20.
`default_nettype none
// ----------------------------------------------------------------------------
// velocity_pid_with_deadband
// Velocity-form PID controller with deadband in fixed point: three-stage
// valid/ready pipeline around the product and accumulate stages.
// ----------------------------------------------------------------------------
module velocity_pid_with_deadband (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    // Configuration write channel
    input  wire                                     cfg_valid,
    output logic                                    cfg_ready,
    input  wire         [vpid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire         [vpid_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input item channel
    input  wire                                     s_valid,
    output logic                                    s_ready,
    input  wire  signed [vpid_pkg::ERR_W-1:0]       s_error_now,
    input  wire  signed [vpid_pkg::ERR_W-1:0]       s_error_prev,
    input  wire  signed [vpid_pkg::ERR_W-1:0]       s_error_prev2,
    // Result item channel
    output logic                                    m_valid,
    input  wire                                     m_ready,
    output logic signed [vpid_pkg::DRIVE_W-1:0]     m_drive_level,
    output logic                                    m_reverse_dir,
    output logic        [vpid_pkg::MAG_W-1:0]       m_drive_magnitude
);
    import vpid_pkg::*;

    cfg_t                    cfg;
    prod_t                   prod;
    logic                    in_valid_reg;
    logic                    prod_valid_reg;
    logic                    out_valid_reg;
    logic                    out_free;
    logic                    prod_free;
    logic                    in_free;
    logic                    load_in;
    logic                    load_prod;
    logic                    load_out;
    logic signed [ERR_W-1:0] e0_reg;
    logic signed [ERR_W-1:0] e1_reg;
    logic signed [ERR_W-1:0] e2_reg;

    assign cfg_ready = 1'b1;

    vpid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    // A stage can take an item when it is empty or its item moves on.
    assign out_free  = !out_valid_reg  || m_ready;
    assign prod_free = !prod_valid_reg || out_free;
    assign in_free   = !in_valid_reg   || prod_free;

    assign load_in   = s_valid        && in_free;
    assign load_prod = in_valid_reg   && prod_free;
    assign load_out  = prod_valid_reg && out_free;

    assign s_ready   = in_free;
    assign m_valid   = out_valid_reg;

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (in_free) begin
                in_valid_reg <= s_valid;
            end
            if (prod_free) begin
                prod_valid_reg <= in_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    // Input register for the three error samples.
    always_ff @(posedge aclk) begin
        if (load_in) begin
            e0_reg <= s_error_now;
            e1_reg <= s_error_prev;
            e2_reg <= s_error_prev2;
        end
    end

    vpid_mul u_mul (
        .aclk (aclk),
        .load (load_prod),
        .e0   (e0_reg),
        .e1   (e1_reg),
        .e2   (e2_reg),
        .cfg  (cfg),
        .prod (prod)
    );

    vpid_acc u_acc (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (load_out),
        .prod            (prod),
        .drive_level     (m_drive_level),
        .reverse_dir     (m_reverse_dir),
        .drive_magnitude (m_drive_magnitude)
    );

    // The drive never leaves plus or minus 1.0.
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_level >= DRIVE_MIN) && (m_drive_level <= DRIVE_MAX))
        else $error("drive level out of range");

    // Direction flag follows the sign of the drive.
    a_dir_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reverse_dir == !m_drive_level[DRIVE_W-1]))
        else $error("direction flag does not match drive sign");

    // A zero drive has zero duty.
    a_zero_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_drive_level == '0)) |-> (m_drive_magnitude == '0))
        else $error("nonzero duty for zero drive");

    // Input is refused only when the whole pipeline is full and stalled.
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && in_valid_reg && prod_valid_reg))
        else $error("input refused with room in the pipeline");

endmodule : velocity_pid_with_deadband
`default_nettype wire

### tb/sv/velocity_pid_with_deadband_test.sv
// ----------------------------------------------------------------------------
// velocity_pid_with_deadband_test
// Self-checking bench for the velocity-form PID controller with deadband.
// Every item accepted on the s_ channel is run through an in-bench copy of
// the controller, and the predicted drive, direction and duty magnitude are
// queued. Each m_ item is checked field by field against the oldest entry.
// The sequence runs directed corner cases first, then randomized control
// runs under changing gains and deadband, with random gaps on both sides.
// ----------------------------------------------------------------------------
module velocity_pid_with_deadband_test;
    import vpid_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      rev;
        logic        [MAG_W-1:0]   mag;
    } drive_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic        [CFG_IDX_W-1:0]   cfg_index;
    logic        [CFG_DATA_W-1:0]  cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic signed [ERR_W-1:0]       s_error_now;
    logic signed [ERR_W-1:0]       s_error_prev;
    logic signed [ERR_W-1:0]       s_error_prev2;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [DRIVE_W-1:0]     m_drive_level;
    logic                          m_reverse_dir;
    logic        [MAG_W-1:0]       m_drive_magnitude;

    // Controller state as the bench tracks it.
    logic signed [GAIN_W-1:0]  gain_kp = '0;
    logic signed [GAIN_W-1:0]  gain_ki = '0;
    logic signed [GAIN_W-1:0]  gain_kd = '0;
    logic        [TOL_W-1:0]   band_tol = TOL_RESET;
    logic signed [DRIVE_W-1:0] held_drive = '0;

    drive_result_t pending_drives[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            idle_on = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    velocity_pid_with_deadband DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_error_now       (s_error_now),
        .s_error_prev      (s_error_prev),
        .s_error_prev2     (s_error_prev2),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_drive_level     (m_drive_level),
        .m_reverse_dir     (m_reverse_dir),
        .m_drive_magnitude (m_drive_magnitude)
    );

    // One control tick: apply the velocity-form increment to the held drive,
    // clamp to plus or minus one, then apply the deadband if no clamp hit.
    function automatic drive_result_t pid_tick(input logic signed [ERR_W-1:0] e0,
                                               input logic signed [ERR_W-1:0] e1,
                                               input logic signed [ERR_W-1:0] e2);
        longint        g0;
        longint        g1;
        longint        g2;
        longint        acc;
        longint        lim;
        longint        d;
        longint        mag_full;
        drive_result_t r;
        g0 = longint'(gain_kp) + longint'(gain_ki) + longint'(gain_kd);
        g1 = longint'(gain_kp) + 2 * longint'(gain_kd);
        g2 = longint'(gain_kd);
        lim = longint'(ONE_Q12) * 256;
        acc = longint'(held_drive) * 256 + g0 * longint'(e0)
              - g1 * longint'(e1) + g2 * longint'(e2);
        if (acc > lim) begin
            d = ONE_Q12;
        end else if (acc < -lim) begin
            d = -ONE_Q12;
        end else if (longint'(e0) < longint'(band_tol)
                     && longint'(e0) > -longint'(band_tol)) begin
            d = 0;
        end else begin
            // Arithmetic shift rounds toward minus infinity.
            d = acc >>> 8;
        end
        held_drive = DRIVE_W'(d);
        mag_full = ((d < 0) ? -d : d) * 255;
        r.drive = DRIVE_W'(d);
        r.rev = (d >= 0);
        r.mag = MAG_W'(mag_full >>> 12);
        return r;
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endfunction

    // Send one error item, with an occasional gap before it.
    task automatic send_item(input logic signed [ERR_W-1:0] e0,
                             input logic signed [ERR_W-1:0] e1,
                             input logic signed [ERR_W-1:0] e2);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_error_now <= e0;
        s_error_prev <= e1;
        s_error_prev2 <= e2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_drives.push_back(pid_tick(e0, e1, e2));
    endtask

    // Stop sending and let the pipeline empty before touching registers.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // One register write; the bench copy follows the write at its handshake.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_KP_GAIN: begin
                gain_kp = data;
            end
            REG_KI_GAIN: begin
                gain_ki = data;
            end
            REG_KD_GAIN: begin
                gain_kd = data;
            end
            REG_DEADBAND: begin
                band_tol = data[TOL_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic load_config(input logic [CFG_DATA_W-1:0] kp,
                               input logic [CFG_DATA_W-1:0] ki,
                               input logic [CFG_DATA_W-1:0] kd,
                               input logic [CFG_DATA_W-1:0] tol);
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KI_GAIN, ki);
        write_reg(REG_KD_GAIN, kd);
        write_reg(REG_DEADBAND, tol);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall bursts while idling is enabled.
    always begin : result_stall
        @(posedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        m_ready <= 1'b1;
    end

    // Compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_check
        drive_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_drives.size() == 0) begin
                report_mismatch($sformatf("unexpected item drive=%0d rev=%0d mag=%0d",
                                          m_drive_level, m_reverse_dir,
                                          m_drive_magnitude));
            end else begin
                want = pending_drives.pop_front();
                if (m_drive_level !== want.drive || m_reverse_dir !== want.rev
                    || m_drive_magnitude !== want.mag) begin
                    report_mismatch($sformatf(
                        "expected drive=%0d rev=%0d mag=%0d, got drive=%0d rev=%0d mag=%0d",
                        want.drive, want.rev, want.mag,
                        m_drive_level, m_reverse_dir, m_drive_magnitude));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("velocity_pid_with_deadband_test: FAIL");
            $finish;
        end
    end

    // Zero gains after reset hold the drive at zero, around the default band.
    task automatic test_reset_defaults();
        send_item(16'sd19, 16'sd0, 16'sd0);
        send_item(16'sd20, -16'sd5, 16'sd7);
        send_item(-16'sd20, 16'sd0, 16'sd0);
        send_item(-16'sd19, 16'sd3, -16'sd3);
    endtask

    // Largest gains and errors of both signs drive the clamp both ways.
    task automatic test_field_extremes();
        wait_idle();
        load_config(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000);
        send_item(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        // Held drive at plus one with zero errors sits exactly on the limit.
        send_item(16'sd0, 16'sd0, 16'sd0);
        send_item(16'sh8000, 16'sh7FFF, 16'sh8000);
        wait_idle();
        load_config(16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_item(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        send_item(16'sh8000, 16'sh7FFF, 16'sh8000);
        send_item(16'sd0, 16'sd0, 16'sd0);
    endtask

    // Band edges, the widest band against the clamp, and a zero band.
    task automatic test_deadband();
        wait_idle();
        load_config(16'sd256, 16'sd0, 16'sd0, 16'd100);
        send_item(16'sd99, 16'sd0, 16'sd0);
        send_item(16'sd100, 16'sd0, 16'sd0);
        send_item(-16'sd100, 16'sd0, 16'sd0);
        send_item(-16'sd99, 16'sd0, 16'sd0);
        wait_idle();
        // Top data bit set: only the low fifteen bits reach the band.
        load_config(16'sd256, 16'sd0, 16'sd0, 16'hFFFF);
        send_item(16'sd32766, 16'sd0, 16'sd0);
        send_item(16'sd1000, 16'sd0, 16'sd0);
        wait_idle();
        load_config(16'sd256, 16'sd0, 16'sd0, 16'h0000);
        send_item(16'sd0, 16'sd0, 16'sd0);
        send_item(-16'sd5, 16'sd0, 16'sd0);
    endtask

    // Tiny gains leave fractional sums that must round toward minus infinity.
    task automatic test_rounding();
        wait_idle();
        load_config(16'sd1, 16'sd2, 16'sd3, 16'h0000);
        send_item(-16'sd1, 16'sd0, 16'sd0);
        send_item(16'sd0, -16'sd1, 16'sd0);
        send_item(16'sd255, 16'sd0, -16'sd7);
        send_item(-16'sd300, 16'sd129, 16'sd77);
    endtask

    // Writes to indexes past the last register must change nothing.
    task automatic test_bad_index();
        wait_idle();
        write_reg(CFG_IDX_W'(int'(REG_DEADBAND) + 1), 16'hFFFF);
        write_reg('1, 16'h8000);
        cfg_valid <= 1'b0;
        send_item(16'sd1234, -16'sd567, 16'sd89);
        send_item(-16'sd4000, 16'sd4000, 16'sd0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_gain(input int style);
        logic [CFG_DATA_W-1:0] g;
        case (style)
            0: begin
                g = CFG_DATA_W'($urandom_range(0, 1023) - 512);
            end
            1: begin
                g = CFG_DATA_W'($urandom);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: g = 16'h8000;
                    1: g = 16'h7FFF;
                    2: g = 16'hFFFF;
                    default: g = 16'h0000;
                endcase
            end
            default: begin
                g = CFG_DATA_W'($urandom_range(0, 127) - 64);
            end
        endcase
        return g;
    endfunction

    task automatic load_random_config();
        int                    style;
        logic [CFG_DATA_W-1:0] tol;
        style = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0: tol = '0;
            1: tol = CFG_DATA_W'($urandom);
            default: tol = {1'($urandom), TOL_W'($urandom_range(0, 300))};
        endcase
        if ($urandom_range(0, 2) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(int'(REG_DEADBAND) + 1,
                                                (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom));
        end
        load_config(random_gain(style), random_gain(style), random_gain(style), tol);
    endtask

    // Mostly a realistic error history that shifts by one sample per tick,
    // with full-range jumps and unrelated triples mixed in.
    task automatic test_random_control(input int count, input bit with_idle);
        logic signed [ERR_W-1:0] h0;
        logic signed [ERR_W-1:0] h1;
        logic signed [ERR_W-1:0] h2;
        wait_idle();
        idle_on = with_idle;
        load_random_config();
        h1 = ERR_W'($urandom_range(0, 4095) - 2048);
        h2 = ERR_W'($urandom_range(0, 4095) - 2048);
        repeat (count) begin
            if ($urandom_range(0, 4) == 0) begin
                send_item(ERR_W'($urandom), ERR_W'($urandom), ERR_W'($urandom));
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    h0 = ERR_W'($urandom);
                end else begin
                    h0 = h1 + ERR_W'($urandom_range(0, 511) - 256);
                end
                send_item(h0, h1, h2);
                h2 = h1;
                h1 = h0;
            end
        end
    endtask

    initial begin : main_sequence
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_error_now = '0;
        s_error_prev = '0;
        s_error_prev2 = '0;
        m_ready = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_deadband();
        test_rounding();
        test_bad_index();
        // The last two runs go without any idling.
        for (int phase = 0; phase < 10; phase++) begin
            test_random_control(55, phase < 8);
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && pending_drives.size() == 0) begin
            $display("velocity_pid_with_deadband_test: PASS");
        end else begin
            $display("velocity_pid_with_deadband_test: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/vpid_pkg.sv
rtl/vpid_cfg.sv
rtl/vpid_mul.sv
rtl/vpid_acc.sv
rtl/velocity_pid_with_deadband.sv
tb/sv/velocity_pid_with_deadband_test.sv
